// ----- hw/rtl/stp_pkg.sv -----
// Shared codes, reset values and widths for the stepper step pulse generator.
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

	// Default sizing
	localparam int DEF_NUM_CHANNELS = 4;
	localparam int DEF_PERIOD_BITS  = 16;

	// Fixed field widths
	localparam int ACTION_W   = 2;
	localparam int CHANNEL_W  = 2;
	localparam int CMD_W      = 16;
	localparam int PHASE_W    = 15;
	localparam int MINPER_W   = 8;
	localparam int OUT_CH     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [PHASE_W-1:0]  SLAVE_INC_RESET  = 15'd1040;
	localparam logic [MINPER_W-1:0] MIN_PERIOD_RESET = 8'd10;

	// Word actions
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK  = 2'd0,
		ACT_CMD   = 2'd1,
		ACT_ILOCK = 2'd2
	} act_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_INC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd1;

endpackage

`default_nettype wire

// ----- hw/rtl/stepper_step_pulse_generator.sv -----
// Four-channel step/direction pulse generator with master/slave interlock.
// Each input word is held in the input register, then its result in the result register.
// Throughput: one word per cycle when unstalled; state update is one pass from input to result.
// Input stall rises only when the input register is full and the result register is held.
// Reset (arst_n low) clears all channel counters, busy and direction bits, the phase
// accumulator, sets interlock on, periods to full scale, slave increment 1040, min period 10.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_pulse_generator #(
	parameter int NUM_CHANNELS = stp_pkg::DEF_NUM_CHANNELS,
	parameter int PERIOD_BITS  = stp_pkg::DEF_PERIOD_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input words
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [stp_pkg::ACTION_W-1:0]     action,
	input  wire logic [stp_pkg::CHANNEL_W-1:0]    channel,
	input  wire logic [stp_pkg::CMD_W-1:0]        period,
	input  wire logic [stp_pkg::CMD_W-1:0]        steps,
	input  wire logic                             direction,
	input  wire logic                             period_only,
	input  wire logic                             interlock_on,
	// result words
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [stp_pkg::OUT_CH-1:0]            step_pulses,
	output logic [stp_pkg::OUT_CH-1:0]            directions,
	output logic [stp_pkg::OUT_CH-1:0]            busy_flags,
	output logic                                  interlocked,
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [stp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PADW = (NUM_CHANNELS > stp_pkg::OUT_CH) ? NUM_CHANNELS : stp_pkg::OUT_CH;
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET =
		(PERIOD_BITS >= stp_pkg::CMD_W) ? PERIOD_BITS'(16'hFFFF) : {PERIOD_BITS{1'b1}};

	// Input register
	logic                            valid_s1;
	logic [stp_pkg::ACTION_W-1:0]    action_s1;
	logic [stp_pkg::CHANNEL_W-1:0]   channel_s1;
	logic [stp_pkg::CMD_W-1:0]       period_s1;
	logic [stp_pkg::CMD_W-1:0]       steps_s1;
	logic                            direction_s1;
	logic                            period_only_s1;
	logic                            interlock_on_s1;

	// Configuration registers
	logic [stp_pkg::PHASE_W-1:0]     slave_inc_q;
	logic [stp_pkg::MINPER_W-1:0]    min_period_q;

	// Channel state
	logic [stp_pkg::CMD_W-1:0]       steps_q   [NUM_CHANNELS];
	logic [PERIOD_BITS-1:0]          per_q     [NUM_CHANNELS];
	logic [PERIOD_BITS-1:0]          cd_q      [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]         busy_q;
	logic [NUM_CHANNELS-1:0]         dir_q;
	logic [stp_pkg::PHASE_W-1:0]     acc_q;
	logic                            ilock_q;

	// Next state
	logic [stp_pkg::CMD_W-1:0]       steps_d   [NUM_CHANNELS];
	logic [PERIOD_BITS-1:0]          per_d     [NUM_CHANNELS];
	logic [PERIOD_BITS-1:0]          cd_d      [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]         busy_d;
	logic [NUM_CHANNELS-1:0]         dir_d;
	logic [stp_pkg::PHASE_W-1:0]     acc_d;
	logic                            ilock_d;
	logic [NUM_CHANNELS-1:0]         pulse_d;
	logic [stp_pkg::PHASE_W:0]       acc_sum;

	// Result register
	logic                            out_valid_q;
	logic [stp_pkg::OUT_CH-1:0]      pulses_q;
	logic [stp_pkg::OUT_CH-1:0]      dirs_q;
	logic [stp_pkg::OUT_CH-1:0]      busys_q;
	logic                            ilock_out_q;

	logic                            adv;
	logic [stp_pkg::CMD_W-1:0]       cmd_clamped;
	logic [PERIOD_BITS-1:0]          cmd_period;
	logic [PADW-1:0]                 pulse_pad;
	logic [PADW-1:0]                 dir_pad;
	logic [PADW-1:0]                 busy_pad;

	// Handshake: advance the input word when the result register is free or draining
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Clamp the commanded period up to min_period, then saturate to the stored width
	assign cmd_clamped = (period_s1 < stp_pkg::CMD_W'(min_period_q))
		? stp_pkg::CMD_W'(min_period_q) : period_s1;

	generate
		if (PERIOD_BITS >= stp_pkg::CMD_W) begin : g_period_wide
			assign cmd_period = PERIOD_BITS'(cmd_clamped);
		end else begin : g_period_narrow
			assign cmd_period = (cmd_clamped > stp_pkg::CMD_W'({PERIOD_BITS{1'b1}}))
				? {PERIOD_BITS{1'b1}} : cmd_clamped[PERIOD_BITS-1:0];
		end
	endgenerate

	// Next state for one word
	always_comb begin
		steps_d = steps_q;
		per_d   = per_q;
		cd_d    = cd_q;
		busy_d  = busy_q;
		dir_d   = dir_q;
		acc_d   = acc_q;
		ilock_d = ilock_q;
		pulse_d = '0;
		acc_sum = {1'b0, acc_q} + {1'b0, slave_inc_q};
		case (action_s1)
			stp_pkg::ACT_TICK: begin
				// time each channel; the slave channel is frozen in interlock
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (!(c == 1 && ilock_q)) begin
						if (busy_q[c] && cd_q[c] != '0) begin
							cd_d[c] = cd_q[c] - 1'b1;
						end else if (steps_q[c] != '0) begin
							steps_d[c] = steps_q[c] - 1'b1;
							busy_d[c]  = 1'b1;
							cd_d[c]    = (per_q[c] == '0) ? '0 : per_q[c] - 1'b1;
							pulse_d[c] = 1'b1;
						end else begin
							busy_d[c] = 1'b0;
						end
					end
				end
				// master step advances the phase; carry out steps the slave
				if (ilock_q && pulse_d[0]) begin
					acc_d = acc_sum[stp_pkg::PHASE_W-1:0];
					if (acc_sum[stp_pkg::PHASE_W]) begin
						pulse_d[1] = 1'b1;
					end
				end
			end
			stp_pkg::ACT_CMD: begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (int'(channel_s1) == c) begin
						per_d[c] = cmd_period;
						if (!period_only_s1) begin
							dir_d[c]   = direction_s1;
							steps_d[c] = steps_s1;
							if (steps_s1 == '0) begin
								busy_d[c] = 1'b0;
							end
						end
					end
				end
				// any command to the slave drops interlock
				if (int'(channel_s1) == 1) begin
					ilock_d = 1'b0;
				end
			end
			stp_pkg::ACT_ILOCK: begin
				ilock_d = interlock_on_s1;
			end
			default: begin
			end
		endcase
	end

	assign pulse_pad = PADW'(pulse_d);
	assign dir_pad   = PADW'(dir_d);
	assign busy_pad  = PADW'(busy_d);

	// Input register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1       <= action;
			channel_s1      <= channel;
			period_s1       <= period;
			steps_s1        <= steps;
			direction_s1    <= direction;
			period_only_s1  <= period_only;
			interlock_on_s1 <= interlock_on;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_inc_q  <= stp_pkg::SLAVE_INC_RESET;
			min_period_q <= stp_pkg::MIN_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == stp_pkg::CFG_SLAVE_INC) begin
				slave_inc_q <= cfg_data[stp_pkg::PHASE_W-1:0];
			end
			if (cfg_index == stp_pkg::CFG_MIN_PERIOD) begin
				min_period_q <= cfg_data[stp_pkg::MINPER_W-1:0];
			end
		end
	end

	// Channel state: update when a word advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				steps_q[c] <= '0;
				per_q[c]   <= PERIOD_RESET;
				cd_q[c]    <= '0;
			end
			busy_q  <= '0;
			dir_q   <= '0;
			acc_q   <= '0;
			ilock_q <= 1'b1;
		end else if (adv) begin
			steps_q <= steps_d;
			per_q   <= per_d;
			cd_q    <= cd_d;
			busy_q  <= busy_d;
			dir_q   <= dir_d;
			acc_q   <= acc_d;
			ilock_q <= ilock_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pulses_q    <= pulse_pad[stp_pkg::OUT_CH-1:0];
			dirs_q      <= dir_pad[stp_pkg::OUT_CH-1:0];
			busys_q     <= busy_pad[stp_pkg::OUT_CH-1:0];
			ilock_out_q <= ilock_d;
		end
	end

	assign step_pulses = pulses_q;
	assign directions  = dirs_q;
	assign busy_flags  = busys_q;
	assign interlocked = ilock_out_q;

	// Checks
	a_no_pulse_off_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 != stp_pkg::ACT_TICK |=> pulses_q == '0)
		else $error("step pulse on a word that is not a tick");

	a_slave_cmd_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 == stp_pkg::ACT_CMD && channel_s1 == 2'd1 |=> !ilock_q)
		else $error("command to slave channel left interlock on");

	a_master_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pulse_d[0] |=> busy_q[0] && busys_q[0])
		else $error("master stepped without starting its period");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with a free pipeline");

endmodule

`default_nettype wire

// ----- sim/tb_stepper_step_pulse_generator.sv -----
// Self-checking testbench for the stepper step pulse generator: scripted and random words.
`timescale 1ns / 1ps

module tb_stepper_step_pulse_generator;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 255;
	localparam int NUM_PHASES    = 6;
	localparam int SCRIPT_LEN    = 24;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AFTER    = 400;

	// Action code that the block must ignore
	localparam logic [stp_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [stp_pkg::ACTION_W-1:0]  action;
		logic [stp_pkg::CHANNEL_W-1:0] chan;
		logic [stp_pkg::CMD_W-1:0]     period;
		logic [stp_pkg::CMD_W-1:0]     steps;
		logic                          dir;
		logic                          ponly;
		logic                          ilock_on;
	} cmd_word_t;

	typedef struct packed {
		logic [stp_pkg::OUT_CH-1:0] pulses;
		logic [stp_pkg::OUT_CH-1:0] dirs;
		logic [stp_pkg::OUT_CH-1:0] busy;
		logic                       ilock;
	} status_t;

	typedef struct packed {
		cmd_word_t w;
		logic      typed;
		status_t   st;
	} script_row_t;

	// Opening script; status typed in where it is obvious, otherwise predicted
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h0, 4'h0, 1'b1}},
		'{'{ACT_SPARE,          2'd3, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1},
			1'b1, '{4'h0, 4'h0, 4'h0, 1'b1}},
		'{'{stp_pkg::ACT_ILOCK, 2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h0, 4'h0, 1'b0}},
		'{'{stp_pkg::ACT_CMD,   2'd0, 16'd0,    16'd3,    1'b1, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h1, 4'h0, 1'b0}},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h1, 4'h1, 4'h1, 1'b0}},
		'{'{stp_pkg::ACT_CMD,   2'd3, 16'hffff, 16'hffff, 1'b1, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h9, 4'h1, 1'b0}},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h8, 4'h9, 4'h9, 1'b0}},
		'{'{stp_pkg::ACT_CMD,   2'd2, 16'd5,    16'd7,    1'b1, 1'b1, 1'b0},
			1'b1, '{4'h0, 4'h9, 4'h9, 1'b0}},
		'{'{stp_pkg::ACT_CMD,   2'd0, 16'd20,   16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h8, 4'h8, 1'b0}},
		'{'{stp_pkg::ACT_ILOCK, 2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1},
			1'b1, '{4'h0, 4'h8, 4'h8, 1'b1}},
		'{'{stp_pkg::ACT_CMD,   2'd0, 16'd12,   16'hffff, 1'b0, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'h8, 4'h8, 1'b1}},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h1, 4'h8, 4'h9, 1'b1}},
		'{'{stp_pkg::ACT_TICK,  2'd1, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_CMD,   2'd1, 16'd1,    16'd4,    1'b1, 1'b0, 1'b0},
			1'b1, '{4'h0, 4'ha, 4'h9, 1'b0}},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0},
			1'b1, '{4'h2, 4'ha, 4'hb, 1'b0}},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_CMD,   2'd3, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_CMD,   2'd2, 16'd3,    16'd2,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{stp_pkg::ACT_ILOCK, 2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{stp_pkg::ACT_TICK,  2'd0, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [stp_pkg::ACTION_W-1:0]  action = '0;
	logic [stp_pkg::CHANNEL_W-1:0] channel = '0;
	logic [stp_pkg::CMD_W-1:0]     period = '0;
	logic [stp_pkg::CMD_W-1:0]     steps = '0;
	logic                          direction = 1'b0;
	logic                          period_only = 1'b0;
	logic                          interlock_on = 1'b0;

	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [stp_pkg::OUT_CH-1:0] step_pulses;
	logic [stp_pkg::OUT_CH-1:0] directions;
	logic [stp_pkg::OUT_CH-1:0] busy_flags;
	logic                       interlocked;

	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [stp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: motor channels, slave phase and registers
	logic [stp_pkg::CMD_W-1:0]    left_steps [stp_pkg::OUT_CH];
	logic [stp_pkg::CMD_W-1:0]    cur_period [stp_pkg::OUT_CH];
	logic [stp_pkg::CMD_W-1:0]    tick_count [stp_pkg::OUT_CH];
	logic                         timing     [stp_pkg::OUT_CH];
	logic                         dir_bit    [stp_pkg::OUT_CH];
	logic [stp_pkg::PHASE_W-1:0]  phase_acc;
	logic                         slaved;
	logic [stp_pkg::PHASE_W-1:0]  slave_step;
	logic [stp_pkg::MINPER_W-1:0] floor_period;

	status_t     pending_status [$];
	int          fail_count = 0;
	int          words_sent = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	stepper_step_pulse_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.channel      (channel),
		.period       (period),
		.steps        (steps),
		.direction    (direction),
		.period_only  (period_only),
		.interlock_on (interlock_on),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_pulses  (step_pulses),
		.directions   (directions),
		.busy_flags   (busy_flags),
		.interlocked  (interlocked),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Advance the motor model by one word and return the status it leaves
	function automatic status_t advance_motors(input cmd_word_t w);
		status_t                   st;
		logic [stp_pkg::CMD_W-1:0] p;
		logic [stp_pkg::PHASE_W:0] sum;
		logic                      stepped;
		st = '0;
		case (w.action)
			stp_pkg::ACT_TICK: begin
				for (int c = 0; c < stp_pkg::OUT_CH; c++) begin
					// Channel 1 keeps its own timing frozen while slaved
					if (!(c == 1 && slaved)) begin
						stepped = 1'b0;
						if (timing[c] && tick_count[c] != '0) begin
							tick_count[c] = tick_count[c] - 1'b1;
						end else begin
							timing[c] = 1'b0;
							if (left_steps[c] != '0) begin
								left_steps[c] = left_steps[c] - 1'b1;
								timing[c] = 1'b1;
								tick_count[c] = (cur_period[c] == '0) ? '0 : cur_period[c] - 1'b1;
								stepped = 1'b1;
							end
						end
						if (stepped) begin
							st.pulses[c] = 1'b1;
							// Master step feeds the slave phase; carry out steps channel 1
							if (c == 0 && slaved) begin
								sum = {1'b0, phase_acc} + {1'b0, slave_step};
								if (sum[stp_pkg::PHASE_W])
									st.pulses[1] = 1'b1;
								phase_acc = sum[stp_pkg::PHASE_W-1:0];
							end
						end
					end
				end
			end
			stp_pkg::ACT_CMD: begin
				p = (w.period < stp_pkg::CMD_W'(floor_period)) ?
					stp_pkg::CMD_W'(floor_period) : w.period;
				cur_period[w.chan] = p;
				if (!w.ponly) begin
					dir_bit[w.chan] = w.dir;
					if (w.steps == '0)
						timing[w.chan] = 1'b0;
					left_steps[w.chan] = w.steps;
				end
				if (w.chan == 1)
					slaved = 1'b0;
			end
			stp_pkg::ACT_ILOCK: begin
				slaved = w.ilock_on;
			end
			default: begin
			end
		endcase
		for (int c = 0; c < stp_pkg::OUT_CH; c++) begin
			st.dirs[c] = dir_bit[c];
			st.busy[c] = timing[c];
		end
		st.ilock = slaved;
		return st;
	endfunction

	// Offer one word after a random gap, hold it until taken, then log its status
	task automatic send_word(input cmd_word_t w, input logic typed, input status_t st_typed);
		int      r;
		int      gap;
		status_t st;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action       <= w.action;
		channel      <= w.chan;
		period       <= w.period;
		steps        <= w.steps;
		direction    <= w.dir;
		period_only  <= w.ponly;
		interlock_on <= w.ilock_on;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		st = advance_motors(w);
		pending_status.push_back(typed ? st_typed : st);
		words_sent++;
	endtask

	task automatic finish_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Write one register and mirror it into the predictor
	task automatic cfg_write(input logic [stp_pkg::CFG_IDX_W-1:0] idx,
			input logic [stp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == stp_pkg::CFG_SLAVE_INC)
			slave_step = data[stp_pkg::PHASE_W-1:0];
		else if (idx == stp_pkg::CFG_MIN_PERIOD)
			floor_period = data[stp_pkg::MINPER_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result word with the oldest predicted status
	always @(posedge clk) begin
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$error("result word arrived with nothing expected");
				fail_count++;
			end else begin
				want = pending_status.pop_front();
				check_field("step_pulses", 8'(want.pulses), 8'(step_pulses));
				check_field("directions", 8'(want.dirs), 8'(directions));
				check_field("busy_flags", 8'(want.busy), 8'(busy_flags));
				check_field("interlocked", 8'(want.ilock), 8'(interlocked));
			end
		end
	end

	// Result side: random stalls, quiet stretches and one long hold-off
	initial begin
		int r;
		int len;
		bit held;
		held = 1'b0;
		@(negedge clk);
		forever begin
			if (!held && words_sent >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 8);
				end else if (r < 90) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else if (r < 97) begin
					out_stall <= 1'b1;
					len = $urandom_range(8, 30);
				end else begin
					out_stall <= 1'b0;
					len = $urandom_range(100, 200);
				end
			end
			repeat (len) @(negedge clk);
		end
	end

	// Watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL stepper_step_pulse_generator");
		$finish;
	end

	initial begin
		cmd_word_t                    w;
		int                           r;
		logic [stp_pkg::PHASE_W-1:0]  inc;
		logic [stp_pkg::MINPER_W-1:0] floor_val;

		// Predictor starts from the reset state
		for (int c = 0; c < stp_pkg::OUT_CH; c++) begin
			left_steps[c] = '0;
			cur_period[c] = '1;
			tick_count[c] = '0;
			timing[c]     = 1'b0;
			dir_bit[c]    = 1'b0;
		end
		phase_acc    = '0;
		slaved       = 1'b1;
		slave_step   = stp_pkg::SLAVE_INC_RESET;
		floor_period = stp_pkg::MIN_PERIOD_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the opening script with reset register values
		for (int i = 0; i < SCRIPT_LEN; i++)
			send_word(SCRIPT[i].w, SCRIPT[i].typed, SCRIPT[i].st);
		finish_input();
		wait_drained();

		// Random phases, each under its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin inc = 15'd32767; floor_val = 8'd1;   end
				1: begin inc = 15'd0;     floor_val = 8'd255; end
				2: begin inc = 15'd1;     floor_val = 8'd1;   end
				3: begin inc = 15'd16384; floor_val = 8'd2;   end
				default: begin
					inc = stp_pkg::PHASE_W'($urandom_range(0, 32767));
					floor_val = stp_pkg::MINPER_W'($urandom_range(1, 255));
				end
			endcase
			cfg_write(stp_pkg::CFG_SLAVE_INC, stp_pkg::CFG_DATA_W'(inc));
			cfg_write(stp_pkg::CFG_MIN_PERIOD, stp_pkg::CFG_DATA_W'(floor_val));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// Mostly ticks so channels run; short periods and step counts, a few wide ones
				r = $urandom_range(0, 99);
				if (r < 65)
					w.action = stp_pkg::ACT_TICK;
				else if (r < 85)
					w.action = stp_pkg::ACT_CMD;
				else if (r < 93)
					w.action = stp_pkg::ACT_ILOCK;
				else
					w.action = ACT_SPARE;
				w.chan = stp_pkg::CHANNEL_W'($urandom_range(0, 3));
				w.period = ($urandom_range(0, 9) == 0) ? stp_pkg::CMD_W'($urandom) :
					stp_pkg::CMD_W'($urandom_range(0, 24));
				w.steps = ($urandom_range(0, 9) == 0) ? stp_pkg::CMD_W'($urandom) :
					stp_pkg::CMD_W'($urandom_range(0, 12));
				w.dir = 1'($urandom_range(0, 1));
				w.ponly = ($urandom_range(0, 4) == 0);
				w.ilock_on = ($urandom_range(0, 9) < 7);
				send_word(w, 1'b0, '0);
			end
			finish_input();
			wait_drained();
		end

		if (fail_count == 0)
			$display("PASS stepper_step_pulse_generator");
		else
			$display("FAIL stepper_step_pulse_generator");
		$finish;
	end

endmodule

// ----- stepper_step_pulse_generator.f -----
hw/rtl/stp_pkg.sv
hw/rtl/stepper_step_pulse_generator.sv
sim/tb_stepper_step_pulse_generator.sv
